### hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the code bit packer: payload structs,
// operation codes, table sizes and the command carried from front to back.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	// Table size and longest accepted code length.
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;

	// Fixed field widths.
	localparam int OP_W   = 2;
	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;

	// Derived sizes.
	localparam int SYM_AW    = $clog2(SYMBOL_COUNT);
	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int ACC_W     = BYTE_W - 1;
	localparam int PEND_W    = 3;
	localparam int VAL_W     = ACC_W + CODE_W;
	localparam int TOT_W     = $clog2(VAL_W + 1);

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Operation codes; the last one is unused and ignored.
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Input beat.
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} hcbp_item_t;

	// Output beat.
	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              last_of_run;
		logic              final_byte;
	} hcbp_result_t;

	// Work command for the packer.
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hcbp_cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} hcbp_qstat_t;

endpackage

### hw/rtl/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Path: an encode passes the lookup stage, the command queue, the packer's
// value register and the output register; a flush skips the value register.
// Throughput: the front takes one beat a cycle while the 4-entry queue has
// room; the packer takes commands while idle, sends a flush at once and an
// encode's bytes one by one, holding while the output is not taken.
// Reset: length valid bits, queue and packer clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit import hcbp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  hcbp_item_t   item_data,
	output logic         result_valid,
	input  logic         result_ready,
	output hcbp_result_t result_data
);

	logic        push;
	logic        pop;
	hcbp_cmd_t   push_cmd;
	hcbp_cmd_t   head_cmd;
	hcbp_qstat_t q_stat;

	// Table writes and lookups.
	hcbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_stat     (q_stat)
	);

	// Command queue.
	hcbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	// Bit packing and output beats.
	hcbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

### hw/rtl/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts input beats, writes loads into the code and length tables, looks
// up encodes and passes encode and flush commands into the queue.
// ----------------------------------------------------------------------------
module hcbp_front import hcbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  hcbp_item_t  item_data,
	output logic        push,
	output hcbp_cmd_t   push_cmd,
	input  hcbp_qstat_t q_stat
);

	localparam logic [SYM_W:0]     SYM_LIMIT = (SYM_W+1)'(SYMBOL_COUNT);
	localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(LEN_LIMIT);

	logic                    accept;
	logic                    in_range;
	logic [SYM_AW-1:0]       addr;
	logic [LEN_W-1:0]        sat_len;
	logic [CODE_W:0]         load_mask;
	logic [CODE_W-1:0]       masked_word;
	logic                    tab_we;
	logic                    tab_re;
	logic [SYMBOL_COUNT-1:0] len_vld_q;
	logic                    valid_s1;
	logic                    flush_s1;
	logic                    vld_s1;
	logic [CODE_W-1:0]       code_rd;
	logic [LEN_W-1:0]        len_rd;
	logic [LEN_W-1:0]        eff_len;
	logic                    drop;
	logic                    done_s1;

	// Decode of the incoming beat.
	assign accept   = item_valid && item_ready;
	assign in_range = {1'b0, item_data.symbol} < SYM_LIMIT;
	assign addr     = item_data.symbol[SYM_AW-1:0];
	assign tab_we   = accept && (item_data.operation == OP_LOAD) && in_range;
	assign tab_re   = accept && (item_data.operation == OP_ENCODE) && in_range;

	// Saturate the length and keep only its low code bits.
	assign sat_len     = (item_data.code_length > LEN_MAX) ? LEN_MAX : item_data.code_length;
	assign load_mask   = ((CODE_W+1)'(1) << sat_len) - (CODE_W+1)'(1);
	assign masked_word = item_data.code_word & load_mask[CODE_W-1:0];

	// Code word table.
	hcbp_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (addr),
		.wdata (masked_word),
		.re    (tab_re),
		.raddr (addr),
		.rdata (code_rd)
	);

	// Code length table.
	hcbp_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOL_COUNT)) u_len_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (addr),
		.wdata (sat_len),
		.re    (tab_re),
		.raddr (addr),
		.rdata (len_rd)
	);

	// Valid bits of the length table; an unwritten entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (tab_we) begin
			len_vld_q[addr] <= 1'b1;
		end
	end

	// Lookup stage: holds one encode or flush until the queue takes it or it is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
			vld_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= tab_re || (item_data.operation == OP_FLUSH);
			flush_s1 <= item_data.operation == OP_FLUSH;
			vld_s1   <= len_vld_q[addr];
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Encodes of symbols without a code are dropped here.
	assign eff_len    = vld_s1 ? len_rd : '0;
	assign drop       = !flush_s1 && (eff_len == '0);
	assign push       = valid_s1 && !drop && !q_stat.full;
	assign done_s1    = valid_s1 && (drop || !q_stat.full);
	assign item_ready = !valid_s1 || done_s1;

	assign push_cmd.flush = flush_s1;
	assign push_cmd.code  = code_rd;
	assign push_cmd.len   = eff_len;

endmodule

### hw/rtl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short command FIFO that decouples table lookup from bit packing.
// ----------------------------------------------------------------------------
module hcbp_queue import hcbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hcbp_cmd_t   push_cmd,
	input  logic        pop,
	output hcbp_cmd_t   head_cmd,
	output hcbp_qstat_t q_stat
);

	localparam logic [QUEUE_AW-1:0] LAST_IDX = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_AW:0]   FULL_CNT = (QUEUE_AW+1)'(QUEUE_DEPTH);

	hcbp_cmd_t           entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_cmd     = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q == FULL_CNT;
	assign q_stat.empty = count_q == '0;

	// The front never writes a full queue and the back never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command popped from an empty queue");

endmodule

### hw/rtl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: appends code bits to the pending accumulator, sends one byte
// per cycle while the output is free and pads the final byte on flush.
// ----------------------------------------------------------------------------
module hcbp_back import hcbp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  hcbp_cmd_t    head_cmd,
	input  hcbp_qstat_t  q_stat,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_ready,
	output hcbp_result_t result_data
);

	localparam logic [TOT_W-1:0] BYTE_BITS = TOT_W'(BYTE_W);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} hcbp_state_t;

	hcbp_state_t       state_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PEND_W-1:0] pend_q;
	logic [VAL_W-1:0]  value_q;
	logic [TOT_W-1:0]  total_q;
	logic              result_valid_q;
	hcbp_result_t      result_q;

	logic              out_free;
	logic              emit;
	logic [VAL_W-1:0]  join_value;
	logic [TOT_W-1:0]  join_total;
	logic [TOT_W-1:0]  rest;
	logic [VAL_W-1:0]  shifted;
	logic [BYTE_W-1:0] rest_mask;
	logic [BYTE_W-1:0] flush_byte;
	logic [3:0]        pad_shift;

	// Mask of the low pending bits for a count below one byte.
	function automatic logic [ACC_W-1:0] rest_mask_short(input logic [TOT_W-1:0] n);
		logic [BYTE_W-1:0] m;
		m = (BYTE_W'(1) << n[PEND_W-1:0]) - BYTE_W'(1);
		return m[ACC_W-1:0];
	endfunction

	assign out_free = !result_valid_q || result_ready;

	// Pending bits followed by the new code, right-aligned.
	assign join_value = (VAL_W'(acc_q) << head_cmd.len) | VAL_W'(head_cmd.code);
	assign join_total = TOT_W'(pend_q) + TOT_W'(head_cmd.len);

	// Next byte is the top eight of the bits still to send.
	assign rest      = total_q - BYTE_BITS;
	assign shifted   = value_q >> rest;
	assign rest_mask = (BYTE_W'(1) << rest[PEND_W-1:0]) - BYTE_W'(1);

	// Flush byte: pending bits moved to the top, zeros below.
	assign pad_shift  = 4'(BYTE_W) - 4'(pend_q);
	assign flush_byte = BYTE_W'({1'b0, acc_q} << pad_shift);

	assign pop = (state_q == ST_IDLE) && !q_stat.empty && (!head_cmd.flush || out_free);

	// A new byte enters the output register on a flush or on a full byte.
	assign emit = (pop && head_cmd.flush) ||
		((state_q == ST_EMIT) && (total_q >= BYTE_BITS) && out_free);

	// Output valid: set by a new byte, cleared once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Packer sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			pend_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head_cmd.flush) begin
						result_q.packed_byte <= flush_byte;
						result_q.last_of_run <= 1'b1;
						result_q.final_byte  <= 1'b1;
						acc_q                <= '0;
						pend_q               <= '0;
					end else if (pop) begin
						value_q <= join_value;
						total_q <= join_total;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (total_q < BYTE_BITS) begin
						// Too few bits for a byte: they all stay pending.
						acc_q   <= value_q[ACC_W-1:0] & rest_mask_short(total_q);
						pend_q  <= total_q[PEND_W-1:0];
						state_q <= ST_IDLE;
					end else if (out_free) begin
						result_q.packed_byte <= shifted[BYTE_W-1:0];
						result_q.last_of_run <= rest < BYTE_BITS;
						result_q.final_byte  <= 1'b0;
						total_q              <= rest;
						if (rest < BYTE_BITS) begin
							acc_q   <= value_q[ACC_W-1:0] & rest_mask[ACC_W-1:0];
							pend_q  <= rest[PEND_W-1:0];
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Bits above the pending count are always clear in the accumulator.
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, acc_q} >> pend_q) == '0))
		else $error("stale bits above the pending count");

	// A padded flush byte always closes its run.
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.final_byte) |-> result_q.last_of_run)
		else $error("flush byte not marked last of run");

endmodule
